FILE: design/apbg_pkg.sv
// Package for the anchor prior box generator: shared constants, register
// indexes, command codes and the structs passed between modules.
// No dependencies.
package apbg_pkg;

	localparam int DEF_MAX_SIZES   = 2;
	localparam int DEF_MAX_RATIOS  = 4;
	localparam int COORD_FRAC_BITS = 16;
	localparam int COORD_W         = 20;

	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 3;

	localparam int UNIT_STEP_W = 7;
	localparam logic [UNIT_STEP_W-1:0] SQRT_STEPS = 7'd30;
	localparam logic [UNIT_STEP_W-1:0] RDIV_STEPS = 7'd60;
	localparam logic [UNIT_STEP_W-1:0] NDIV_STEPS = 7'd20;

	// corner numerator: doubled centre +/- side with fraction shift and rounding term
	localparam int NUM_W = 39 + COORD_FRAC_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_COUNT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_COUNT   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OPTION_FLAGS  = 3'd7;

	localparam logic [1:0] CMD_LOAD_SIZE  = 2'd0;
	localparam logic [1:0] CMD_LOAD_RATIO = 2'd1;
	localparam logic [1:0] CMD_GENERATE   = 2'd2;

	localparam int OPT_MAX  = 0;
	localparam int OPT_FLIP = 1;
	localparam int OPT_CLIP = 2;

	typedef struct packed {
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic [19:0] step_x;
		logic [19:0] step_y;
		logic [7:0]  center_offset;
		logic [1:0]  size_count;
		logic [2:0]  ratio_count;
		logic [2:0]  option_flags;
	} cfg_t;

	typedef struct packed {
		logic                   start;
		logic                   op_sqrt;
		logic [UNIT_STEP_W-1:0] steps;
		logic [33:0]            rem_init;
		logic [63:0]            src;
		logic [29:0]            divisor;
	} unit_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} unit_rsp_t;

endpackage

FILE: design/apbg_if.sv
// Channel interfaces of the anchor prior box generator: command input and
// box output, valid/ready handshake. No dependencies.
interface apbg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [1:0]  entry_index;
	logic [9:0]  min_px;
	logic [9:0]  max_px;
	logic [15:0] ratio_q8;
	logic [7:0]  cell_row;
	logic [7:0]  cell_col;

	modport source (output valid, command, entry_index, min_px, max_px,
		ratio_q8, cell_row, cell_col, input ready);
	modport sink (input valid, command, entry_index, min_px, max_px,
		ratio_q8, cell_row, cell_col, output ready);
endinterface

interface apbg_out_if;
	logic               valid;
	logic               ready;
	logic signed [19:0] x_min;
	logic signed [19:0] y_min;
	logic signed [19:0] x_max;
	logic signed [19:0] y_max;
	logic               last_box;

	modport source (output valid, x_min, y_min, x_max, y_max, last_box, input ready);
	modport sink (input valid, x_min, y_min, x_max, y_max, last_box, output ready);
endinterface

FILE: design/apbg_cfg.sv
// Configuration register file of the anchor prior box generator.
// Depends on apbg_pkg.
module apbg_cfg
	import apbg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= 13'd300;
			cfg_q.image_height  <= 13'd300;
			cfg_q.step_x        <= 20'd2048;
			cfg_q.step_y        <= 20'd2048;
			cfg_q.center_offset <= 8'd128;
			cfg_q.size_count    <= 2'd1;
			cfg_q.ratio_count   <= 3'd0;
			cfg_q.option_flags  <= 3'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[12:0];
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data[12:0];
				REG_STEP_X:        cfg_q.step_x        <= cfg_data[19:0];
				REG_STEP_Y:        cfg_q.step_y        <= cfg_data[19:0];
				REG_CENTER_OFFSET: cfg_q.center_offset <= cfg_data[7:0];
				REG_SIZE_COUNT:    cfg_q.size_count    <= cfg_data[1:0];
				REG_RATIO_COUNT:   cfg_q.ratio_count   <= cfg_data[2:0];
				REG_OPTION_FLAGS:  cfg_q.option_flags  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/apbg_unit.sv
// Shared radix-2 unit: restoring division (one quotient bit per cycle) or
// integer square root (one root bit per cycle) on one 35-bit subtractor.
// Depends on apbg_pkg.
module apbg_unit
	import apbg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  unit_cmd_t cmd,
	output unit_rsp_t rsp
);

	logic                   busy_q;
	logic                   done_q;
	logic [UNIT_STEP_W-1:0] cnt_q;
	logic                   op_q;
	logic [33:0]            rem_q;
	logic [63:0]            src_q;
	logic [29:0]            dvs_q;
	logic [63:0]            res_q;

	logic [33:0] cand;
	logic [33:0] trial;
	logic [34:0] diff;
	logic        ge;

	always_comb begin
		if (op_q) begin
			cand  = {rem_q[31:0], src_q[63:62]};
			trial = {res_q[31:0], 2'b01};
		end else begin
			cand  = {rem_q[32:0], src_q[63]};
			trial = {4'b0, dvs_q};
		end
		diff = {1'b0, cand} - {1'b0, trial};
		ge   = !diff[34];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == UNIT_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= cmd.op_sqrt;
			rem_q <= cmd.rem_init;
			src_q <= cmd.src;
			dvs_q <= cmd.divisor;
			res_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[33:0] : cand;
			res_q <= {res_q[62:0], ge};
			src_q <= op_q ? {src_q[61:0], 2'b00} : {src_q[62:0], 1'b0};
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

FILE: design/anchor_prior_box_generator_top.sv
// Anchor prior box generator. Load commands are accepted back to back. A generate
// command runs a sequencer over one shared divide/sqrt unit: centre setup, size setup
// per size, then per box four corners (setup, a 20-step division and a store each; a
// corner that saturates skips the division) and a hand-off; the sqrt(min*max) box first
// runs a 30-step root, each ratio box a 30+60+30 step root/division/root. Not ready
// while a generate runs, output stalls included. arst_n clears control and config.
module anchor_prior_box_generator_top
	import apbg_pkg::*;
#(
	parameter int MAX_SIZES  = DEF_MAX_SIZES,
	parameter int MAX_RATIOS = DEF_MAX_RATIOS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	apbg_in_if.sink               in_ch,
	apbg_out_if.source            out_ch
);

	localparam int SIDX_W = (MAX_SIZES > 1) ? $clog2(MAX_SIZES) : 1;
	localparam int RIDX_W = (MAX_RATIOS > 1) ? $clog2(MAX_RATIOS) : 1;
	localparam int SCNT_W = $clog2(MAX_SIZES + 1);
	localparam int RCNT_W = $clog2(MAX_RATIOS + 1);
	localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1 << COORD_FRAC_BITS);
	localparam logic [COORD_W-1:0] COORD_HI  = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_LO  = {1'b1, {(COORD_W-1){1'b0}}};

	typedef enum logic [4:0] {
		ST_IDLE, ST_CX, ST_CY, ST_CY2, ST_SZ, ST_SZ2,
		ST_MX_MUL, ST_MX_SQ, ST_MX_WAIT,
		ST_R_MUL, ST_R_SQW, ST_R_WAITW, ST_R_DIV, ST_R_WAITD, ST_R_SQH, ST_R_WAITH,
		ST_NA, ST_NB, ST_NC, ST_NWAIT, ST_NFIN, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {BOX_SQ, BOX_MX, BOX_RP, BOX_RF} box_t;

	cfg_t      cfg;
	unit_cmd_t ucmd;
	unit_rsp_t ursp;

	apbg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	apbg_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ucmd),
		.rsp    (ursp)
	);

	logic [9:0]  min_tab [MAX_SIZES];
	logic [9:0]  max_tab [MAX_SIZES];
	logic [15:0] ratio_tab [MAX_RATIOS];

	state_t              state_q;
	box_t                kind_q;
	logic [SCNT_W-1:0]   s_q, ns_q;
	logic [RCNT_W-1:0]   r_q, nr_q;
	logic [7:0]          row_q, col_q;
	logic [39:0]         prod_q;
	logic [36:0]         cx2_q, cy2_q;
	logic [19:0]         mn2_q;
	logic [29:0]         w_q, h_q;
	logic [1:0]          k_q;
	logic [38:0]         n_q;
	logic                neg_q, sat_q;
	logic [NUM_W-1:0]    num_q;
	logic [COORD_W-1:0]  coord_q [4];
	logic                out_valid_q, last_q;
	logic [COORD_W-1:0]  out_coord_q [4];

	logic                in_acc;
	logic [SCNT_W-1:0]   ns_c;
	logic [RCNT_W-1:0]   nr_c;
	logic [9:0]          mn, mx;
	logic [15:0]         a_raw, a_eff;
	logic [19:0]         mul_a, mul_b;
	logic [39:0]         prod;
	logic                mul_en;
	logic [12:0]         dim_raw, dim_c;
	logic [36:0]         base_c;
	logic [29:0]         side_c;
	logic [37:0]         mag_c;
	logic                sat_c;
	logic [COORD_W-1:0]  q_c, coord_c;
	logic                s_last, r_last, seq_end, out_free;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	assign ns_c = (int'(cfg.size_count) > MAX_SIZES) ? SCNT_W'(MAX_SIZES)
		: SCNT_W'(cfg.size_count);
	assign nr_c = (int'(cfg.ratio_count) > MAX_RATIOS) ? RCNT_W'(MAX_RATIOS)
		: RCNT_W'(cfg.ratio_count);

	always_ff @(posedge clk) begin
		if (in_acc && in_ch.command == CMD_LOAD_SIZE && int'(in_ch.entry_index) < MAX_SIZES) begin
			min_tab[SIDX_W'(in_ch.entry_index)] <= in_ch.min_px;
			max_tab[SIDX_W'(in_ch.entry_index)] <= in_ch.max_px;
		end
		if (in_acc && in_ch.command == CMD_LOAD_RATIO && int'(in_ch.entry_index) < MAX_RATIOS)
			ratio_tab[RIDX_W'(in_ch.entry_index)] <= in_ch.ratio_q8;
	end

	assign mn    = min_tab[s_q[SIDX_W-1:0]];
	assign mx    = max_tab[s_q[SIDX_W-1:0]];
	assign a_raw = ratio_tab[r_q[RIDX_W-1:0]];
	assign a_eff = (a_raw == 16'd0) ? 16'd1 : a_raw;

	// shared multiplier, operands chosen by state
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (state_q)
			ST_CX: begin
				mul_a = {4'b0, col_q, cfg.center_offset};
				mul_b = cfg.step_x;
			end
			ST_CY: begin
				mul_a = {4'b0, row_q, cfg.center_offset};
				mul_b = cfg.step_y;
			end
			ST_SZ: begin
				mul_a = {10'b0, mn};
				mul_b = {10'b0, mn};
			end
			ST_MX_MUL: begin
				mul_a = {10'b0, mn};
				mul_b = {10'b0, mx};
			end
			ST_R_MUL: begin
				mul_a = mn2_q;
				mul_b = {4'b0, a_eff};
			end
			default: mul_en = 1'b0;
		endcase
		prod = mul_a * mul_b;
	end

	// corner path
	assign dim_raw = k_q[0] ? cfg.image_height : cfg.image_width;
	assign dim_c   = (dim_raw == 13'd0) ? 13'd1 : dim_raw;
	assign base_c  = k_q[0] ? cy2_q : cx2_q;
	assign side_c  = k_q[0] ? h_q : w_q;
	assign mag_c   = n_q[38] ? 38'(-n_q) : n_q[37:0];
	assign sat_c   = 64'(num_q) >= (64'(dim_c) << 37);
	assign q_c     = ursp.result[COORD_W-1:0];

	always_comb begin
		if (cfg.option_flags[OPT_CLIP]) begin
			if (neg_q)
				coord_c = '0;
			else if (sat_q || q_c > COORD_ONE)
				coord_c = COORD_ONE;
			else
				coord_c = q_c;
		end else if (neg_q) begin
			if (sat_q || q_c > COORD_LO)
				coord_c = COORD_LO;
			else
				coord_c = COORD_W'(-q_c);
		end else begin
			if (sat_q || q_c > COORD_HI)
				coord_c = COORD_HI;
			else
				coord_c = q_c;
		end
	end

	// unit commands
	always_comb begin
		ucmd = '0;
		case (state_q)
			ST_MX_SQ: begin
				ucmd.start   = 1'b1;
				ucmd.op_sqrt = 1'b1;
				ucmd.steps   = SQRT_STEPS;
				ucmd.src     = {8'b0, prod_q[19:0], 32'b0, 4'b0};
			end
			ST_R_SQW: begin
				ucmd.start   = 1'b1;
				ucmd.op_sqrt = 1'b1;
				ucmd.steps   = SQRT_STEPS;
				ucmd.src     = {prod_q[35:0], 24'b0, 4'b0};
			end
			ST_R_DIV: begin
				ucmd.start   = 1'b1;
				ucmd.steps   = RDIV_STEPS;
				ucmd.src     = {mn2_q, 40'b0, 4'b0};
				ucmd.divisor = {14'b0, a_eff};
			end
			ST_R_SQH: begin
				ucmd.start   = 1'b1;
				ucmd.op_sqrt = 1'b1;
				ucmd.steps   = SQRT_STEPS;
				ucmd.src     = {ursp.result[59:0], 4'b0};
			end
			ST_NC: begin
				ucmd.start    = !sat_c;
				ucmd.steps    = NDIV_STEPS;
				ucmd.rem_init = 34'(num_q >> 20);
				ucmd.src      = {num_q[19:0], 44'b0};
				ucmd.divisor  = {dim_c, 17'b0};
			end
			default: ;
		endcase
	end

	assign s_last   = (SCNT_W'(s_q + 1'b1) == ns_q);
	assign r_last   = (RCNT_W'(r_q + 1'b1) == nr_q);
	assign out_free = !out_valid_q || out_ch.ready;

	always_comb begin
		case (kind_q)
			BOX_SQ:  seq_end = !cfg.option_flags[OPT_MAX] && nr_q == '0;
			BOX_MX:  seq_end = (nr_q == '0);
			BOX_RP:  seq_end = !cfg.option_flags[OPT_FLIP] && r_last;
			BOX_RF:  seq_end = r_last;
			default: seq_end = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= BOX_SQ;
			s_q         <= '0;
			ns_q        <= '0;
			r_q         <= '0;
			nr_q        <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (mul_en)
				prod_q <= prod;
			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_ch.command == CMD_GENERATE && ns_c != '0) begin
						row_q   <= in_ch.cell_row;
						col_q   <= in_ch.cell_col;
						ns_q    <= ns_c;
						nr_q    <= nr_c;
						s_q     <= '0;
						state_q <= ST_CX;
					end
				end
				ST_CX: state_q <= ST_CY;
				ST_CY: begin
					cx2_q   <= {prod_q[35:0], 1'b0};
					state_q <= ST_CY2;
				end
				ST_CY2: begin
					cy2_q   <= {prod_q[35:0], 1'b0};
					state_q <= ST_SZ;
				end
				ST_SZ: state_q <= ST_SZ2;
				ST_SZ2: begin
					mn2_q   <= prod_q[19:0];
					w_q     <= {4'b0, mn, 16'b0};
					h_q     <= {4'b0, mn, 16'b0};
					r_q     <= '0;
					kind_q  <= BOX_SQ;
					k_q     <= '0;
					state_q <= ST_NA;
				end
				ST_MX_MUL: state_q <= ST_MX_SQ;
				ST_MX_SQ:  state_q <= ST_MX_WAIT;
				ST_MX_WAIT: begin
					if (ursp.done) begin
						w_q     <= ursp.result[29:0];
						h_q     <= ursp.result[29:0];
						kind_q  <= BOX_MX;
						k_q     <= '0;
						state_q <= ST_NA;
					end
				end
				ST_R_MUL: state_q <= ST_R_SQW;
				ST_R_SQW: state_q <= ST_R_WAITW;
				ST_R_WAITW: begin
					if (ursp.done) begin
						w_q     <= ursp.result[29:0];
						state_q <= ST_R_DIV;
					end
				end
				ST_R_DIV: state_q <= ST_R_WAITD;
				ST_R_WAITD: begin
					if (ursp.done)
						state_q <= ST_R_SQH;
				end
				ST_R_SQH: state_q <= ST_R_WAITH;
				ST_R_WAITH: begin
					if (ursp.done) begin
						h_q     <= ursp.result[29:0];
						kind_q  <= BOX_RP;
						k_q     <= '0;
						state_q <= ST_NA;
					end
				end
				ST_NA: begin
					n_q     <= k_q[1] ? 39'(base_c) + 39'(side_c) : 39'(base_c) - 39'(side_c);
					state_q <= ST_NB;
				end
				ST_NB: begin
					neg_q   <= n_q[38];
					num_q   <= (NUM_W'(mag_c) << COORD_FRAC_BITS) + (NUM_W'(dim_c) << 16);
					state_q <= ST_NC;
				end
				ST_NC: begin
					sat_q   <= sat_c;
					state_q <= sat_c ? ST_NFIN : ST_NWAIT;
				end
				ST_NWAIT: begin
					if (ursp.done)
						state_q <= ST_NFIN;
				end
				ST_NFIN: begin
					coord_q[k_q] <= coord_c;
					k_q          <= k_q + 1'b1;
					state_q      <= (k_q == 2'd3) ? ST_EMIT : ST_NA;
				end
				ST_EMIT: begin
					if (out_free) begin
						last_q      <= seq_end && s_last;
						out_coord_q <= coord_q;
						if (kind_q == BOX_SQ && cfg.option_flags[OPT_MAX]) begin
							state_q <= ST_MX_MUL;
						end else if (kind_q == BOX_RP && cfg.option_flags[OPT_FLIP]) begin
							w_q     <= h_q;
							h_q     <= w_q;
							kind_q  <= BOX_RF;
							state_q <= ST_NA;
						end else if ((kind_q == BOX_SQ || kind_q == BOX_MX) && nr_q != '0) begin
							r_q     <= '0;
							state_q <= ST_R_MUL;
						end else if ((kind_q == BOX_RP || kind_q == BOX_RF) && !r_last) begin
							r_q     <= r_q + 1'b1;
							state_q <= ST_R_MUL;
						end else if (!s_last) begin
							s_q     <= s_q + 1'b1;
							state_q <= ST_SZ;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.last_box = last_q;
	assign out_ch.x_min    = out_coord_q[0];
	assign out_ch.y_min    = out_coord_q[1];
	assign out_ch.x_max    = out_coord_q[2];
	assign out_ch.y_max    = out_coord_q[3];

endmodule

FILE: design/apbg_chk.sv
// Port-level checker for the anchor prior box generator, bound to the top.
// Depends on apbg_pkg and anchor_prior_box_generator_top.
module apbg_chk
	import apbg_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic [1:0]   in_command,
	input logic         out_valid,
	input logic         out_ready,
	input logic         out_last_box,
	input logic [19:0]  out_x_min
);

	// a stalled transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("output valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_x_min))
		else $error("output payload changed while stalled");

	// boxes still to come for this cell: block must be busy
	a_busy_mid_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_last_box) |-> !in_ready)
		else $error("ready while a cell is unfinished");

	// table loads and the unused command code complete at once
	a_load_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_command != CMD_GENERATE) |=> in_ready)
		else $error("not ready after a load command");

endmodule

bind anchor_prior_box_generator_top apbg_chk u_apbg_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_command   (in_ch.command),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_last_box (out_ch.last_box),
	.out_x_min    (out_ch.x_min)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for anchor_prior_box_generator_top: loads size and ratio tables, sends
// generate commands and checks every box against a scoreboard that models the block.
// Depends on apbg_pkg, apbg_in_if, apbg_out_if and the top-level RTL.
module tb;
	import apbg_pkg::*;

	typedef struct {
		logic [1:0]  command;
		logic [1:0]  entry_index;
		logic [9:0]  min_px;
		logic [9:0]  max_px;
		logic [15:0] ratio_q8;
		logic [7:0]  cell_row;
		logic [7:0]  cell_col;
	} cmd_t;

	typedef struct {
		logic [19:0] x_min;
		logic [19:0] y_min;
		logic [19:0] x_max;
		logic [19:0] y_max;
		logic        last_box;
	} box_t;

	class box_scoreboard;
		cfg_t            cfg;
		logic [9:0]      min_tab[DEF_MAX_SIZES];
		logic [9:0]      max_tab[DEF_MAX_SIZES];
		logic [15:0]     ratio_tab[DEF_MAX_RATIOS];
		box_t            expected_boxes[$];
		int              errors;
		int              boxes_seen;
		int              cells_seen;

		function new();
			cfg.image_width   = 13'd300;
			cfg.image_height  = 13'd300;
			cfg.step_x        = 20'd2048;
			cfg.step_y        = 20'd2048;
			cfg.center_offset = 8'd128;
			cfg.size_count    = 2'd1;
			cfg.ratio_count   = 3'd0;
			cfg.option_flags  = 3'd0;
			errors = 0;
			boxes_seen = 0;
			cells_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_IMAGE_WIDTH: cfg.image_width = val[12:0];
				REG_IMAGE_HEIGHT: cfg.image_height = val[12:0];
				REG_STEP_X: cfg.step_x = val;
				REG_STEP_Y: cfg.step_y = val;
				REG_CENTER_OFFSET: cfg.center_offset = val[7:0];
				REG_SIZE_COUNT: cfg.size_count = val[1:0];
				REG_RATIO_COUNT: cfg.ratio_count = val[2:0];
				default: cfg.option_flags = val[2:0];
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else
					r = r >> 1;
				b = b >> 2;
			end
			return r;
		endfunction

		function logic [19:0] to_coord(longint signed n, logic [12:0] dim);
			longint unsigned mag;
			longint unsigned d;
			longint unsigned q;
			longint signed v;
			mag = (n < 0) ? longint'(-n) : n;
			d = ((dim == 0) ? 64'd1 : 64'(dim)) << 17;
			q = ((mag << COORD_FRAC_BITS) + d / 2) / d;
			v = (n < 0) ? -longint'(q) : longint'(q);
			if (cfg.option_flags[OPT_CLIP]) begin
				if (v < 0) v = 0;
				if (v > (64'sd1 << COORD_FRAC_BITS)) v = 64'sd1 << COORD_FRAC_BITS;
			end
			if (v > 524287) v = 524287;
			if (v < -524288) v = -524288;
			return v[19:0];
		endfunction

		function void push_box(longint signed cx2, longint signed cy2, longint signed w,
				longint signed h);
			box_t b;
			b.x_min = to_coord(cx2 - w, cfg.image_width);
			b.y_min = to_coord(cy2 - h, cfg.image_height);
			b.x_max = to_coord(cx2 + w, cfg.image_width);
			b.y_max = to_coord(cy2 + h, cfg.image_height);
			b.last_box = 1'b0;
			expected_boxes.push_back(b);
		endfunction

		function void note_command(cmd_t c);
			int ns;
			int nr;
			int before_n;
			longint signed cx2;
			longint signed cy2;
			longint unsigned mn;
			longint unsigned mx;
			longint unsigned a;
			longint signed w;
			longint signed h;
			if (c.command == CMD_LOAD_SIZE) begin
				if (c.entry_index < DEF_MAX_SIZES) begin
					min_tab[c.entry_index] = c.min_px;
					max_tab[c.entry_index] = c.max_px;
				end
				return;
			end
			if (c.command == CMD_LOAD_RATIO) begin
				if (c.entry_index < DEF_MAX_RATIOS) ratio_tab[c.entry_index] = c.ratio_q8;
				return;
			end
			if (c.command != CMD_GENERATE) return;
			cells_seen++;
			ns = (cfg.size_count > DEF_MAX_SIZES) ? DEF_MAX_SIZES : cfg.size_count;
			nr = (cfg.ratio_count > DEF_MAX_RATIOS) ? DEF_MAX_RATIOS : cfg.ratio_count;
			cx2 = ((64'(c.cell_col) << 8) + cfg.center_offset) * 64'(cfg.step_x) * 2;
			cy2 = ((64'(c.cell_row) << 8) + cfg.center_offset) * 64'(cfg.step_y) * 2;
			before_n = expected_boxes.size();
			for (int s = 0; s < ns; s++) begin
				mn = min_tab[s];
				mx = max_tab[s];
				push_box(cx2, cy2, mn << 16, mn << 16);
				if (cfg.option_flags[OPT_MAX]) begin
					w = int_sqrt((mn * mx) << 32);
					push_box(cx2, cy2, w, w);
				end
				for (int r = 0; r < nr; r++) begin
					a = ratio_tab[r];
					if (a == 0) a = 1;
					w = int_sqrt((mn * mn * a) << 24);
					h = int_sqrt(((mn * mn) << 40) / a);
					push_box(cx2, cy2, w, h);
					if (cfg.option_flags[OPT_FLIP]) push_box(cx2, cy2, h, w);
				end
			end
			if (expected_boxes.size() > before_n)
				expected_boxes[expected_boxes.size()-1].last_box = 1'b1;
		endfunction

		function void check_box(box_t got);
			box_t e;
			boxes_seen++;
			if (expected_boxes.size() == 0) begin
				$error("unexpected box x_min=%0d", $signed(got.x_min));
				errors++;
				return;
			end
			e = expected_boxes.pop_front();
			if (got.x_min !== e.x_min) begin
				$error("x_min exp %0d got %0d", $signed(e.x_min), $signed(got.x_min));
				errors++;
			end
			if (got.y_min !== e.y_min) begin
				$error("y_min exp %0d got %0d", $signed(e.y_min), $signed(got.y_min));
				errors++;
			end
			if (got.x_max !== e.x_max) begin
				$error("x_max exp %0d got %0d", $signed(e.x_max), $signed(got.x_max));
				errors++;
			end
			if (got.y_max !== e.y_max) begin
				$error("y_max exp %0d got %0d", $signed(e.y_max), $signed(got.y_max));
				errors++;
			end
			if (got.last_box !== e.last_box) begin
				$error("last_box exp %0b got %0b", e.last_box, got.last_box);
				errors++;
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 40000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    send_idle_pct;
	int                    recv_idle_pct;
	int                    hold_left;
	int                    quiet_cycles;
	int                    items_sent;
	box_scoreboard         sb;

	apbg_in_if  in_ch();
	apbg_out_if out_ch();

	anchor_prior_box_generator_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		out_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		box_t b;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			b.x_min = out_ch.x_min;
			b.y_min = out_ch.y_min;
			b.x_max = out_ch.x_max;
			b.y_max = out_ch.y_max;
			b.last_box = out_ch.last_box;
			sb.check_box(b);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_cmd(cmd_t c);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_ch.valid        <= 1'b1;
		in_ch.command      <= c.command;
		in_ch.entry_index  <= c.entry_index;
		in_ch.min_px       <= c.min_px;
		in_ch.max_px       <= c.max_px;
		in_ch.ratio_q8     <= c.ratio_q8;
		in_ch.cell_row     <= c.cell_row;
		in_ch.cell_col     <= c.cell_col;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_command(c);
		items_sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.expected_boxes.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	function automatic cmd_t make_cmd(logic [1:0] op, logic [1:0] idx, logic [9:0] mn,
			logic [9:0] mx, logic [15:0] ar, logic [7:0] row, logic [7:0] col);
		cmd_t c;
		c.command = op;
		c.entry_index = idx;
		c.min_px = mn;
		c.max_px = mx;
		c.ratio_q8 = ar;
		c.cell_row = row;
		c.cell_col = col;
		return c;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		int pick;
		int rsel;
		c = make_cmd(2'($urandom_range(3)), 2'($urandom_range(3)), 10'($urandom),
			10'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
		pick = $urandom_range(99);
		if (pick < 62) c.command = CMD_GENERATE;
		else if (pick < 78) c.command = CMD_LOAD_SIZE;
		else if (pick < 95) c.command = CMD_LOAD_RATIO;
		else c.command = 2'd3;
		rsel = $urandom_range(9);
		if (rsel == 0) c.ratio_q8 = 16'd0;
		else if (rsel == 1) c.ratio_q8 = 16'hFFFF;
		else if (rsel < 6) c.ratio_q8 = 16'($urandom_range(64, 1024));
		return c;
	endfunction

	function automatic logic [19:0] pick_dim();
		case ($urandom_range(5))
			0: return 20'd1;
			1: return 20'd4096;
			2: return 20'd0;
			3: return 20'($urandom_range(4097, 8191));
			default: return 20'($urandom_range(1, 4096));
		endcase
	endfunction

	function automatic logic [19:0] pick_step();
		case ($urandom_range(4))
			0: return 20'd1;
			1: return 20'hFFFFF;
			2: return 20'd0;
			default: return 20'($urandom_range(1, 20'hFFFFF));
		endcase
	endfunction

	initial begin
		cmd_t c;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		quiet_cycles = 0;
		items_sent = 0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_LOAD_SIZE;
		in_ch.entry_index = '0;
		in_ch.min_px = '0;
		in_ch.max_px = '0;
		in_ch.ratio_q8 = '0;
		in_ch.cell_row = '0;
		in_ch.cell_col = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tables filled first so that no generate reads an unwritten slot
		send_cmd(make_cmd(CMD_LOAD_SIZE, 2'd0, 10'd30, 10'd60, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(CMD_LOAD_SIZE, 2'd1, 10'd1023, 10'd1023, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(CMD_LOAD_SIZE, 2'd2, 10'd5, 10'd5, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(CMD_LOAD_SIZE, 2'd3, 10'd7, 10'd7, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(CMD_LOAD_RATIO, 2'd0, 10'd0, 10'd0, 16'd512, 8'd0, 8'd0));
		send_cmd(make_cmd(CMD_LOAD_RATIO, 2'd1, 10'd0, 10'd0, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(CMD_LOAD_RATIO, 2'd2, 10'd0, 10'd0, 16'hFFFF, 8'd0, 8'd0));
		send_cmd(make_cmd(CMD_LOAD_RATIO, 2'd3, 10'd0, 10'd0, 16'd1, 8'd0, 8'd0));
		send_cmd(make_cmd(2'd3, 2'd0, 10'd0, 10'd0, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(CMD_GENERATE, 2'd0, 10'd0, 10'd0, 16'd0, 8'd0, 8'd0));
		send_cmd(make_cmd(CMD_GENERATE, 2'd0, 10'd0, 10'd0, 16'd0, 8'd255, 8'd255));
		drain();
		write_reg(REG_SIZE_COUNT, 20'd3);
		write_reg(REG_RATIO_COUNT, 20'd7);
		write_reg(REG_OPTION_FLAGS, 20'd7);
		write_reg(REG_IMAGE_WIDTH, 20'd1);
		write_reg(REG_IMAGE_HEIGHT, 20'd0);
		send_cmd(make_cmd(CMD_GENERATE, 2'd3, 10'h3FF, 10'h3FF, 16'hFFFF, 8'd0, 8'd0));
		send_cmd(make_cmd(CMD_GENERATE, 2'd1, 10'd0, 10'd0, 16'd0, 8'd255, 8'd0));
		drain();
		write_reg(REG_OPTION_FLAGS, 20'd3);
		write_reg(REG_IMAGE_WIDTH, 20'd4096);
		write_reg(REG_IMAGE_HEIGHT, 20'd8191);
		write_reg(REG_STEP_X, 20'hFFFFF);
		write_reg(REG_STEP_Y, 20'd1);
		write_reg(REG_CENTER_OFFSET, 20'd255);
		send_cmd(make_cmd(CMD_GENERATE, 2'd2, 10'd0, 10'd0, 16'd0, 8'd255, 8'd255));
		send_cmd(make_cmd(CMD_GENERATE, 2'd0, 10'd0, 10'd0, 16'd0, 8'd17, 8'd200));
		drain();
		write_reg(REG_SIZE_COUNT, 20'd0);
		write_reg(REG_CENTER_OFFSET, 20'd0);
		send_cmd(make_cmd(CMD_GENERATE, 2'd0, 10'd0, 10'd0, 16'd0, 8'd3, 8'd4));
		drain();

		for (int phase = 0; phase < 12; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
				1: begin send_idle_pct = 53; recv_idle_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_idle_pct = 53; end
				default: begin send_idle_pct = 17; recv_idle_pct = 17; end
			endcase
			write_reg(REG_IMAGE_WIDTH, pick_dim());
			write_reg(REG_IMAGE_HEIGHT, pick_dim());
			write_reg(REG_STEP_X, pick_step());
			write_reg(REG_STEP_Y, pick_step());
			write_reg(REG_CENTER_OFFSET, 20'($urandom_range(255)));
			write_reg(REG_SIZE_COUNT, 20'($urandom_range(3) == 0 ? $urandom_range(3) : 1 + $urandom_range(1)));
			write_reg(REG_RATIO_COUNT, 20'($urandom_range(4) == 0 ? $urandom_range(7) : $urandom_range(2)));
			write_reg(REG_OPTION_FLAGS, 20'($urandom_range(7)));
			if (phase == 5) hold_left <= 3000;
			repeat (28) begin
				c = random_cmd();
				send_cmd(c);
			end
			drain();
		end

		repeat (200) @(posedge clk);
		$display("Run covered %0d commands, %0d cells and %0d boxes over 12 random phases.",
			items_sent, sb.cells_seen, sb.boxes_seen);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
